// ----- design/dgb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dgb_pkg;

  // Configuration register indexes and widths
  localparam int CFG_W = 13;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd2940;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd2016;

  // Luma weights, 16 fraction bits
  localparam logic [15:0] COEF_R = 16'd13933;
  localparam logic [15:0] COEF_G = 16'd46871;
  localparam logic [15:0] COEF_B = 16'd4732;

  // Divide by 25 as multiply by 5243 and shift by 17 (exact for sums up to 6375)
  localparam logic [12:0] BOX_DIV_MUL   = 13'd5243;
  localparam int          BOX_DIV_SHIFT = 17;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Result kinds
  localparam logic KIND_GRAY = 1'b0;
  localparam logic KIND_BOX  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [9:0] col;
    logic [9:0] row;
    logic [7:0] value;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// ----- design/dgb_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dgb_queue
  import dgb_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             push;
  logic             pop;

  assign push_ready = (count != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop)      count <= count + (PW+1)'(1);
      else if (pop && !push) count <= count - (PW+1)'(1);
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ----- design/dgb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dgb_front
  import dgb_pkg::*;
#(
  parameter int MAX_DEC_COLS  = 1024,
  parameter int MAX_FULL_SIZE = 4096,
  parameter int QW            = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       red,
  input  wire logic [7:0]       green,
  input  wire logic [7:0]       blue,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output logic [QW-1:0]         q_data
);

  localparam int CW  = $clog2(MAX_FULL_SIZE);
  localparam int SW  = $clog2(MAX_FULL_SIZE + 1);
  localparam int EW  = (SW > CFG_W) ? SW : CFG_W;
  localparam int DCW = $clog2(MAX_DEC_COLS);
  localparam int GYW = CW - 2;

  function automatic logic [SW-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [EW-1:0] wide;
    wide = EW'(v);
    if (v == '0) return SW'(1);
    else if (wide > EW'(MAX_FULL_SIZE)) return SW'(MAX_FULL_SIZE);
    else return SW'(v);
  endfunction

  function automatic logic [SW-1:0] dec_cols(input logic [SW-1:0] e);
    if (int'(e >> 2) > MAX_DEC_COLS) return SW'(MAX_DEC_COLS);
    else return e >> 2;
  endfunction

  logic [SW-1:0] eff_w;
  logic [SW-1:0] eff_h;
  logic [SW-1:0] dec_w;
  logic [SW-1:0] dec_h;
  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic          fr_valid;
  logic [QW-1:0] fr_data;

  logic          accept;
  logic          keep;
  logic [SW:0]   col_inc;
  logic [SW:0]   row_inc;
  logic          col_wrap;
  logic          row_wrap;
  logic [23:0]   gray_prod;
  logic [7:0]    gray;

  assign in_ready = !fr_valid || q_ready;
  assign accept   = in_valid && in_ready;
  assign q_valid  = fr_valid;
  assign q_data   = fr_data;

  // Classify the pixel at the current raster position
  always_comb begin
    keep = (col[1:0] == 2'b00) && (row[1:0] == 2'b00) &&
           (SW'(col >> 2) < dec_w) && (SW'(row >> 2) < dec_h);
    col_inc  = (SW+1)'(col) + (SW+1)'(1);
    row_inc  = (SW+1)'(row) + (SW+1)'(1);
    col_wrap = (col_inc >= (SW+1)'(eff_w));
    row_wrap = (row_inc >= (SW+1)'(eff_h));
  end

  // Luma in fixed point, truncated
  assign gray_prod = 24'(COEF_R) * 24'(red) + 24'(COEF_G) * 24'(green) +
                     24'(COEF_B) * 24'(blue);
  assign gray = gray_prod[23:16];

  // Hold frame geometry, raster counters and the output flag
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w    <= eff_size(FRAME_WIDTH_RESET);
      eff_h    <= eff_size(FRAME_HEIGHT_RESET);
      dec_w    <= dec_cols(eff_size(FRAME_WIDTH_RESET));
      dec_h    <= eff_size(FRAME_HEIGHT_RESET) >> 2;
      col      <= '0;
      row      <= '0;
      fr_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            eff_w <= eff_size(cfg_data);
            dec_w <= dec_cols(eff_size(cfg_data));
          end
          REG_FRAME_HEIGHT: begin
            eff_h <= eff_size(cfg_data);
            dec_h <= eff_size(cfg_data) >> 2;
          end
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (col_wrap) begin
          col <= '0;
          row <= row_wrap ? '0 : CW'(row_inc);
        end else begin
          col <= CW'(col_inc);
        end
        fr_valid <= keep;
      end else if (q_ready) begin
        fr_valid <= 1'b0;
      end
    end
  end

  // Capture decimated position and gray level
  always_ff @(posedge clk) begin
    if (accept && keep) fr_data <= {DCW'(col >> 2), GYW'(row >> 2), gray};
  end

endmodule

`default_nettype wire

// ----- design/dgb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dgb_back
  import dgb_pkg::*;
#(
  parameter int MAX_DEC_COLS  = 1024,
  parameter int MAX_FULL_SIZE = 4096,
  parameter int QW            = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire logic [QW-1:0] q_data,
  output logic               res_valid,
  input  wire logic          res_ready,
  output result_t            res
);

  localparam int CW  = $clog2(MAX_FULL_SIZE);
  localparam int DCW = $clog2(MAX_DEC_COLS);
  localparam int GYW = CW - 2;

  logic           adv;
  logic           pop;
  logic [DCW-1:0] h_gx;
  logic [GYW-1:0] h_gy;
  logic [7:0]     h_gray;
  logic [7:0]     rd [4];

  logic           b2_v;
  logic [DCW-1:0] b2_gx;
  logic [GYW-1:0] b2_gy;
  logic [7:0]     b2_gray;

  logic [10:0]    cols [4];
  logic [10:0]    vsum;
  logic [12:0]    total;

  logic           b3_v;
  logic [DCW-1:0] b3_gx;
  logic [GYW-1:0] b3_gy;
  logic [7:0]     b3_gray;
  logic [12:0]    b3_total;
  logic           b3_two;

  logic [25:0]    qprod;
  result_t        gray_res;
  result_t        box_res;

  logic           ob_v;
  logic           has_next;
  result_t        cur;
  result_t        nxt;

  // Pipeline moves when the output buffer can take a new item
  assign adv     = !ob_v || (res_ready && !has_next);
  assign q_ready = adv;
  assign pop     = q_valid && adv;

  assign h_gx   = q_data[QW-1 -: DCW];
  assign h_gy   = q_data[8 +: GYW];
  assign h_gray = q_data[7:0];

  // Four line memories, one per decimated row mod 4; read old value, write new
  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic [7:0] mem [MAX_DEC_COLS];
    always_ff @(posedge clk) begin
      if (pop) begin
        rd[i] <= mem[h_gx];
        if (h_gy[1:0] == 2'(i)) mem[h_gx] <= h_gray;
      end
    end
  end

  // Vertical sum of the column and horizontal window total
  always_comb begin
    if (b2_gy >= GYW'(4)) begin
      vsum = 11'(rd[0]) + 11'(rd[1]) + 11'(rd[2]) + 11'(rd[3]) + 11'(b2_gray);
    end else begin
      vsum = '0;
    end
    total = 13'(cols[0]) + 13'(cols[1]) + 13'(cols[2]) + 13'(cols[3]) + 13'(vsum);
  end

  // Window mean and the two candidate results
  always_comb begin
    qprod          = 26'(b3_total) * 26'(BOX_DIV_MUL);
    gray_res.kind  = KIND_GRAY;
    gray_res.col   = 10'(b3_gx);
    gray_res.row   = 10'(b3_gy);
    gray_res.value = b3_gray;
    gray_res.last  = !b3_two;
    box_res.kind   = KIND_BOX;
    box_res.col    = 10'(b3_gx - DCW'(2));
    box_res.row    = 10'(b3_gy - GYW'(2));
    box_res.value  = qprod[BOX_DIV_SHIFT +: 8];
    box_res.last   = 1'b1;
  end

  assign res_valid = ob_v;
  assign res       = cur;

  // Control: stage valids, column sums, output buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      b2_v     <= 1'b0;
      b3_v     <= 1'b0;
      ob_v     <= 1'b0;
      has_next <= 1'b0;
      for (int i = 0; i < 4; i++) cols[i] <= '0;
    end else begin
      if (adv) begin
        b2_v <= pop;
        b3_v <= b2_v;
        if (b2_v) begin
          cols[0] <= cols[1];
          cols[1] <= cols[2];
          cols[2] <= cols[3];
          cols[3] <= vsum;
        end
      end
      if (adv && b3_v) begin
        ob_v     <= 1'b1;
        has_next <= b3_two;
      end else if (ob_v && res_ready) begin
        if (has_next) has_next <= 1'b0;
        else          ob_v     <= 1'b0;
      end
    end
  end

  // Payload: stage registers and result buffer
  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop) begin
        b2_gx   <= h_gx;
        b2_gy   <= h_gy;
        b2_gray <= h_gray;
      end
      if (b2_v) begin
        b3_gx    <= b2_gx;
        b3_gy    <= b2_gy;
        b3_gray  <= b2_gray;
        b3_total <= total;
        b3_two   <= (b2_gx >= DCW'(4)) && (b2_gy >= GYW'(4));
      end
    end
    if (adv && b3_v) begin
      cur <= gray_res;
      nxt <= box_res;
    end else if (ob_v && res_ready && has_next) begin
      cur <= nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/decimate_gray_box5_pipeline.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Decimate-by-4 luma converter with a 5x5 box mean. Full-resolution RGB pixels
// enter in raster order. A pixel whose column and row are both multiples of 4
// (inside the decimated frame) yields a gray result (kind 0); once its 5x5
// decimated window is complete it also yields the window mean for the centre
// two columns and two rows back (kind 1), right after the gray result, with
// last set on the final result of the pixel. Other pixels yield nothing. The
// input side takes one pixel per clock while in_ready is high and the output
// side gives one result per clock while out_ready is high; the four-entry
// queue between the classifying front end and the filtering back end absorbs
// pixels with two results. From input transfer to first result a pixel passes
// front register, queue, line-memory read, column sum and mean. The window
// rows come from four line memories of MAX_DEC_COLS bytes each (one per
// decimated row mod 4), all read and one written per kept pixel; they need no
// clearing after reset, since the top four decimated rows of a frame never
// use them. Frame size is set through cfg_we/cfg_index/cfg_data, which the
// user must do only while no pixel is in flight (the block does not enforce
// it); a size of zero acts as one and sizes above MAX_FULL_SIZE are clamped.
module decimate_gray_box5_pipeline
  import dgb_pkg::*;
#(
  parameter int MAX_DEC_COLS  = 1024,
  parameter int MAX_FULL_SIZE = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       red,
  input  wire logic [7:0]       green,
  input  wire logic [7:0]       blue,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  kind,
  output logic [9:0]            out_col,
  output logic [9:0]            out_row,
  output logic [7:0]            pixel_value,
  output logic                  last
);

  localparam int CW  = $clog2(MAX_FULL_SIZE);
  localparam int DCW = $clog2(MAX_DEC_COLS);
  localparam int QW  = DCW + (CW - 2) + 8;

  logic          f_valid;
  logic          f_ready;
  logic [QW-1:0] f_data;
  logic          b_valid;
  logic          b_ready;
  logic [QW-1:0] b_data;
  result_t       res;

  dgb_front #(
    .MAX_DEC_COLS (MAX_DEC_COLS),
    .MAX_FULL_SIZE(MAX_FULL_SIZE),
    .QW           (QW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  dgb_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data (f_data),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_data)
  );

  dgb_back #(
    .MAX_DEC_COLS (MAX_DEC_COLS),
    .MAX_FULL_SIZE(MAX_FULL_SIZE),
    .QW           (QW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_data   (b_data),
    .res_valid(out_valid),
    .res_ready(out_ready),
    .res      (res)
  );

  assign kind        = res.kind;
  assign out_col     = res.col;
  assign out_row     = res.row;
  assign pixel_value = res.value;
  assign last        = res.last;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import dgb_pkg::*;

  localparam int DEC_COLS       = 1024;
  localparam int FULL_MAX       = 4096;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 208;
  localparam int RANDOM_ITEMS   = 4 * PHASE_ITEMS;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             idx;
    logic [CFG_W-1:0] data;
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
    logic             pin;
    logic [7:0]       luma;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       red;
  logic [7:0]       green;
  logic [7:0]       blue;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             kind;
  logic [9:0]       out_col;
  logic [9:0]       out_row;
  logic [7:0]       pixel_value;
  logic             last;

  // Typed gray level that travels with the pixel, used by the directed rows
  logic             pin_luma;
  logic [7:0]       pinned_luma;

  // Shadow of the block: registers, raster position, line store, column sums
  logic [CFG_W-1:0] width_reg  = FRAME_WIDTH_RESET;
  logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RESET;
  int unsigned      at_col = 0;
  int unsigned      at_row = 0;
  logic [7:0]       luma_lines [0:3][0:DEC_COLS-1];
  logic [10:0]      col_sums [0:4] = '{default: '0};

  result_t          due_pixels[$];
  result_t          want;

  int               sender_gap_pct = 0;
  int               stall_pct = 0;
  int               quiet_cycles = 0;
  int               faults = 0;
  int               pixels_total = 0;
  int               kept_total = 0;
  int               gray_checked = 0;
  int               box_checked = 0;

  plan_row_t        plan [0:24];

  decimate_gray_box5_pipeline dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .out_col     (out_col),
    .out_row     (out_row),
    .pixel_value (pixel_value),
    .last        (last)
  );

  always #5 clk = ~clk;

  // Zero acts as one, anything past the largest frame is clamped
  function automatic int unsigned frame_extent(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > CFG_W'(FULL_MAX)) return FULL_MAX;
    return 32'(v);
  endfunction

  // Random channel: either free-running with extra weight on the rails,
  // or a noisy level around a per-frame base so the means spread out
  function automatic logic [7:0] pick_channel(input int base);
    int v;
    if (base < 0) begin
      case ($urandom_range(7))
        0: return 8'd0;
        1: return 8'd255;
        default: return 8'($urandom_range(255));
      endcase
    end
    v = base + int'($urandom_range(24)) - 12;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Gray level of a kept pixel and, once its 5x5 window is complete, the box
  // mean two columns and two rows back; advance the raster position
  task automatic luma_and_box_for(input logic [7:0] r, g, b, input logic pin,
                                  input logic [7:0] pval);
    int unsigned w, h, dw, dh, gx, gy, luma, vsum, total;
    result_t     res;
    w  = frame_extent(width_reg);
    h  = frame_extent(height_reg);
    dw = w / 4;
    if (dw > DEC_COLS) dw = DEC_COLS;
    dh = h / 4;
    if (at_col % 4 == 0 && at_row % 4 == 0 && at_col / 4 < dw && at_row / 4 < dh) begin
      gx   = at_col / 4;
      gy   = at_row / 4;
      luma = (32'(COEF_R) * r + 32'(COEF_G) * g + 32'(COEF_B) * b) >> 16;
      vsum = 0;
      if (gy >= 4) begin
        vsum = luma + luma_lines[0][gx] + luma_lines[1][gx] + luma_lines[2][gx]
               + luma_lines[3][gx];
      end
      luma_lines[gy % 4][gx] = luma[7:0];
      for (int i = 0; i < 4; i++) col_sums[i] = col_sums[i + 1];
      col_sums[4] = vsum[10:0];

      res.kind  = KIND_GRAY;
      res.col   = gx[9:0];
      res.row   = gy[9:0];
      res.value = pin ? pval : luma[7:0];
      res.last  = !(gx >= 4 && gy >= 4);
      due_pixels.push_back(res);
      if (gx >= 4 && gy >= 4) begin
        total = 0;
        for (int i = 0; i < 5; i++) total += col_sums[i];
        res.kind  = KIND_BOX;
        res.col   = 10'(gx - 2);
        res.row   = 10'(gy - 2);
        res.value = 8'(total / 25);
        res.last  = 1'b1;
        due_pixels.push_back(res);
      end
      kept_total++;
    end

    if (at_col + 1 >= w) begin
      at_col = 0;
      at_row = (at_row + 1 >= h) ? 0 : at_row + 1;
    end else begin
      at_col = at_col + 1;
    end
    pixels_total++;
  endtask

  // Drive one pixel with random gaps ahead of it; return once transferred
  task automatic send_pixel(input logic [7:0] r, g, b, input logic pin,
                            input logic [7:0] pval);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    pin_luma    <= pin;
    pinned_luma <= pval;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Write a register once the block has drained
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  // Random receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Predict on every input transfer, check every output transfer, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) luma_and_box_for(red, green, blue, pin_luma, pinned_luma);

      if (out_valid && out_ready) begin
        if (due_pixels.size() == 0) begin
          $error("unexpected result: kind %0d col %0d row %0d value %0d",
                 kind, out_col, out_row, pixel_value);
          faults++;
        end else begin
          want = due_pixels.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            faults++;
          end
          if (out_col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_col);
            faults++;
          end
          if (out_row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_row);
            faults++;
          end
          if (pixel_value !== want.value) begin
            $error("pixel_value: expected %0d, got %0d", want.value, pixel_value);
            faults++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            faults++;
          end
          if (want.kind == KIND_BOX) box_checked++;
          else gray_checked++;
        end
      end

      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: timeout, %0d results still due", due_pixels.size());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int w, h, reps, base, sent, n;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_FRAME_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    red         = '0;
    green       = '0;
    blue        = '0;
    pin_luma    = 1'b0;
    pinned_luma = '0;

    // Directed walk, starting in the reset-size frame: rails, a shrink below
    // the current position, zero sizes, oversize clamp, back to frame start
    plan = '{
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd128, 8'd64,  8'd32,  1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd255, 8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_WRITE, REG_FRAME_WIDTH,  13'd4,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd255, 8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_WRITE, REG_FRAME_HEIGHT, 13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd255, 8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd255, 8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd0,   8'd255, 1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd0,   8'd255, 1'b0, 8'd0},
      '{ROW_WRITE, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
      '{ROW_WRITE, REG_FRAME_WIDTH,  13'd8191, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_WRITE, REG_FRAME_HEIGHT, 13'd8191, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd255, 8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd255, 8'd0,   1'b0, 8'd0},
      '{ROW_WRITE, REG_FRAME_WIDTH,  13'd1,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_WRITE, REG_FRAME_HEIGHT, 13'd1,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd0,   8'd255, 1'b0, 8'd0}
    };

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].data);
      else send_pixel(plan[i].r, plan[i].g, plan[i].b, plan[i].pin, plan[i].luma);
    end

    // Random frames, each starting at frame start; the idling mix advances
    // every PHASE_ITEMS pixels, so a frame may span two mixes
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(3) == 0) begin
        w = $urandom_range(9);
        h = $urandom_range(9);
      end else begin
        w = $urandom_range(28, 20);
        h = $urandom_range(24, 20);
      end
      write_reg(REG_FRAME_WIDTH, 13'(w));
      write_reg(REG_FRAME_HEIGHT, 13'(h));
      reps = ($urandom_range(3) == 0) ? 2 : 1;
      base = ($urandom_range(2) == 0) ? int'($urandom_range(255)) : -1;
      n = reps * int'(frame_extent(13'(w)) * frame_extent(13'(h)));
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      repeat (n) begin
        case (sent / PHASE_ITEMS)
          0: begin sender_gap_pct = 0;  stall_pct = 0;  end
          1: begin sender_gap_pct = 66; stall_pct = 0;  end
          2: begin sender_gap_pct = 0;  stall_pct = 66; end
          default: begin sender_gap_pct = 29; stall_pct = 29; end
        endcase
        send_pixel(pick_channel(base), pick_channel(base), pick_channel(base), 1'b0, 8'd0);
        sent++;
      end
    end

    // Drain, then give any stray result time to show up
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("tb: %0d pixels in, %0d kept, frames from 1x1 up to 4096 wide",
             pixels_total, kept_total);
    $display("tb: %0d gray and %0d box results checked under four idling mixes",
             gray_checked, box_checked);
    if (faults == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
